// ===== src/tap_pkg.sv =====
// Shared types, codes and constants for the touch converter poll sequencer.
// No dependencies; every other file in src imports this package.
package tap_pkg;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned OUT_TUSER_W = 3;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [7:0]  CMD_X            = 8'hc8;
    localparam logic [7:0]  CMD_Y            = 8'hd8;
    localparam logic [15:0] DEBOUNCE_DEFAULT = 16'd10;

    typedef enum logic [1:0] {
        REQ_POLL   = 2'd0,
        REQ_READ   = 2'd1,
        REQ_TX     = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SEND   = 2'd1,
        ACT_READ   = 2'd2,
        ACT_REINIT = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_X    = 2'd1,
        TGT_Y    = 2'd2
    } t_target;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_DEBOUNCE = 4'd1,
        PH_SEND_X   = 4'd2,
        PH_TX_X     = 4'd3,
        PH_RD_X     = 4'd4,
        PH_SEND_Y   = 4'd5,
        PH_TX_Y     = 4'd6,
        PH_RD_Y     = 4'd7,
        PH_ERR      = 4'd8
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;

    typedef struct packed {
        logic [7:0]  read_byte_low;
        logic [7:0]  read_byte_high;
        logic        start_accepted;
        logic [31:0] now_ticks;
        logic        pen_down;
        t_req        req_type;
    } t_item;

    typedef struct packed {
        logic [11:0] pos_y;
        logic [11:0] pos_x;
        logic        touch_valid;
        logic [7:0]  command_byte;
        t_action     action;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] time_mark;
        logic        tx_done;
        logic        rd_done;
        t_target     read_target;
        logic [11:0] held_x;
        logic [11:0] held_y;
    } t_state;

    typedef struct packed {
        logic        enabled;
        logic [15:0] debounce_ticks;
    } t_cfg;

endpackage

// ===== src/touch_adc_poll_sequencer.sv =====
// Top level of the touch converter poll sequencer: stream ports, registers and config.
// Depends on tap_pkg and tap_step.
//
// This block drives a resistive touch converter on a serial bus, one request at a time.
// Each request (a poll, a read completion or a transmit done) produces exactly one
// response, so a caller can pair them in order. A request is captured into an input
// register, evaluated by a short combinational step against the sequencer state, and
// the response is written into the output register when that register is free or is
// being drained; one request is taken every cycle while the response side drains. The
// rate is set only by the step logic between those two registers, whose longest path is
// the 32-bit wrapping tick compare used for debounce. The output register decouples the
// two sides: a new request is captured while a finished response waits to be taken.
// Configuration (enable and debounce length) is written through its own port, which is
// always ready, and should only be written while no request is in flight. With enable
// low, every request returns an all-zero response and the state does not move.
module touch_adc_poll_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata from bit 0: pen_down[0], now_ticks[32:1], start_accepted[33],
    // read_byte_high[41:34], read_byte_low[49:42], zero pad [55:50].
    input  logic [tap_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // tuser: req_type[1:0].
    input  logic [1:0]                       i_s_tuser,
    // Response channel.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata from bit 0: command_byte[7:0], pos_x[19:8], pos_y[31:20].
    output logic [tap_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // tuser from bit 0: action[1:0], touch_valid[2].
    output logic [tap_pkg::OUT_TUSER_W-1:0]  o_m_tuser,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tap_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tap_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tap_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;

    t_state  n_state;
    t_result n_result;
    logic    step_go;
    logic    take_in;

    // The step fires when the input register holds a request and the output register
    // is empty or is being drained this cycle.
    assign step_go    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step_go;
    assign take_in    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    tap_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled        <= 1'b0;
            r_cfg.debounce_ticks <= DEBOUNCE_DEFAULT;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ENABLED) begin
                r_cfg.enabled <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_DEBOUNCE) begin
                r_cfg.debounce_ticks <= i_cfg_data;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in.req_type       <= t_req'(i_s_tuser);
            r_in.pen_down       <= i_s_tdata[0];
            r_in.now_ticks      <= i_s_tdata[32:1];
            r_in.start_accepted <= i_s_tdata[33];
            r_in.read_byte_high <= i_s_tdata[41:34];
            r_in.read_byte_low  <= i_s_tdata[49:42];
        end
    end

    // Sequencer state advances once per evaluated request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.time_mark   <= '0;
            r_state.tx_done     <= 1'b0;
            r_state.rd_done     <= 1'b0;
            r_state.read_target <= TGT_NONE;
            r_state.held_x      <= '0;
            r_state.held_y      <= '0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.pos_y, r_out.pos_x, r_out.command_byte};
    assign o_m_tuser  = {r_out.touch_valid, r_out.action};

endmodule

// ===== src/tap_step.sv =====
// Combinational step of the poll sequencer: one request against the current state.
// Depends on tap_pkg for the state, request and result types.
module tap_step (
    input  tap_pkg::t_cfg    i_cfg,
    input  tap_pkg::t_state  i_state,
    input  tap_pkg::t_item   i_item,
    output tap_pkg::t_state  o_state,
    output tap_pkg::t_result o_result
);
    import tap_pkg::*;

    logic        poll;
    logic [31:0] elapsed;
    logic        settled;
    logic [11:0] sample;
    t_phase      next_phase;

    assign poll    = i_cfg.enabled && (i_item.req_type == REQ_POLL);
    assign elapsed = i_item.now_ticks - i_state.time_mark;
    assign settled = elapsed > {16'd0, i_cfg.debounce_ticks};
    assign sample  = {i_item.read_byte_high, i_item.read_byte_low[7:4]};

    // Next phase.
    always_comb begin
        next_phase = i_state.phase;
        if (poll) begin
            if (i_state.phase == PH_ERR) begin
                next_phase = PH_IDLE;
            end else if (i_state.phase == PH_IDLE) begin
                if (i_item.pen_down) begin
                    next_phase = PH_DEBOUNCE;
                end
            end else if (!i_item.pen_down) begin
                next_phase = PH_IDLE;
            end else begin
                case (i_state.phase)
                    PH_DEBOUNCE: if (settled) next_phase = PH_SEND_X;
                    PH_SEND_X: begin
                        next_phase = i_item.start_accepted ? PH_TX_X : PH_ERR;
                    end
                    PH_TX_X:   if (i_state.tx_done) next_phase = PH_RD_X;
                    PH_RD_X:   if (i_state.rd_done) next_phase = PH_SEND_Y;
                    PH_SEND_Y: begin
                        next_phase = i_item.start_accepted ? PH_TX_Y : PH_ERR;
                    end
                    PH_TX_Y:   if (i_state.tx_done) next_phase = PH_RD_Y;
                    PH_RD_Y:   if (i_state.rd_done) next_phase = PH_SEND_X;
                    default:   next_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Result, flags and held data.
    always_comb begin
        o_result            = '0;
        o_state.phase       = next_phase;
        o_state.time_mark   = i_state.time_mark;
        o_state.tx_done     = i_state.tx_done;
        o_state.rd_done     = i_state.rd_done;
        o_state.read_target = i_state.read_target;
        o_state.held_x      = i_state.held_x;
        o_state.held_y      = i_state.held_y;
        if (i_cfg.enabled) begin
            case (i_item.req_type)
                REQ_READ: begin
                    if (i_state.read_target == TGT_X) begin
                        o_state.held_x  = sample;
                        o_state.rd_done = 1'b1;
                    end else if (i_state.read_target == TGT_Y) begin
                        o_state.held_y  = sample;
                        o_state.rd_done = 1'b1;
                    end
                end
                REQ_TX: o_state.tx_done = 1'b1;
                REQ_POLL: begin
                    if (i_state.phase == PH_ERR) begin
                        o_result.action = ACT_REINIT;
                    end else if (i_state.phase == PH_IDLE) begin
                        if (i_item.pen_down) o_state.time_mark = i_item.now_ticks;
                    end else if (i_item.pen_down) begin
                        case (i_state.phase)
                            PH_DEBOUNCE: if (settled) o_state.time_mark = i_item.now_ticks;
                            PH_SEND_X, PH_SEND_Y: begin
                                o_state.tx_done       = 1'b0;
                                o_result.action       = ACT_SEND;
                                o_result.command_byte =
                                    (i_state.phase == PH_SEND_X) ? CMD_X : CMD_Y;
                            end
                            PH_TX_X, PH_TX_Y: begin
                                if (i_state.tx_done) begin
                                    o_state.rd_done     = 1'b0;
                                    o_state.read_target =
                                        (i_state.phase == PH_TX_X) ? TGT_X : TGT_Y;
                                    o_result.action     = ACT_READ;
                                end
                            end
                            PH_RD_Y: begin
                                if (i_state.rd_done) begin
                                    o_result.touch_valid = 1'b1;
                                    o_result.pos_x       = i_state.held_x;
                                    o_result.pos_y       = i_state.held_y;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== src/tap_checker.sv =====
// Port-level checks for the touch converter poll sequencer, bound to its top level.
// Depends on tap_pkg and touch_adc_poll_sequencer.
module tap_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [tap_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic [tap_pkg::OUT_TUSER_W-1:0]  o_m_tuser
);
    import tap_pkg::*;

    // A stalled response must stay put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("response changed while stalled");

    // A published coordinate pair never rides with a bus action.
    a_pair_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> o_m_tuser[1:0] == ACT_NONE)
        else $error("coordinates published together with a bus action");

    // A send carries one of the two conversion commands; otherwise the byte is zero.
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[1:0] == ACT_SEND)
            ? (o_m_tdata[7:0] == CMD_X || o_m_tdata[7:0] == CMD_Y)
            : (o_m_tdata[7:0] == 8'd0))
        else $error("bad command byte");

    // Coordinates are zero unless a pair is published.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[2] |-> o_m_tdata[31:8] == 24'd0)
        else $error("coordinates present without a published pair");

endmodule

bind touch_adc_poll_sequencer tap_checker u_tap_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== dv/touch_adc_poll_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for touch_adc_poll_sequencer: directed and random request
// streams, checked against a predictor of the sampling sequencer. Depends on tap_pkg.

module touch_adc_poll_sequencer_tb;

    import tap_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int PIPE_LATENCY   = 2;    // request register plus response register
    localparam int IDLE_PCT       = 24;   // chance per cycle that either side idles
    localparam int RX_HOLD_CYCLES = 60;   // long response hold-off for the pressure test
    localparam int QUIET_LIMIT    = 2000; // cycles with no handshake at all before giving up

    // ------------------------------------------------------------------
    // Clock, reset and block inputs. Every input has a known value from
    // time zero; after that all of them change only at rising edges.
    // ------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [1:0]             i_s_tuser   = '0;
    logic                   i_m_tready  = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;
    logic                   o_cfg_ready;

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    touch_adc_poll_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: the testbench's own copy of the sequencer registers
    // and configuration, starting from their reset values.
    // ------------------------------------------------------------------
    logic        cfg_en       = 1'b0;
    logic [15:0] cfg_debounce = DEBOUNCE_DEFAULT;
    t_phase      mdl_phase    = PH_IDLE;
    logic [31:0] tick_mark    = '0;
    logic        tx_seen      = 1'b0;
    logic        rd_seen      = 1'b0;
    t_target     fill_target  = TGT_NONE;
    logic [11:0] raw_x        = '0;
    logic [11:0] raw_y        = '0;

    // Responses still owed by the block, oldest first.
    t_result     pending_responses[$];

    // Run control and bookkeeping.
    bit tx_gaps     = 1'b1;
    bit rx_gaps     = 1'b1;
    bit rx_hold_ask = 1'b0;
    int mismatch_cnt = 0;
    int sent_cnt     = 0;
    int checked_cnt  = 0;
    int touch_cnt    = 0;
    int cfg_cnt      = 0;
    int quiet_cycles = 0;

    // Works out the response to one accepted request and advances the
    // predicted sequencer state. With the device absent nothing moves and
    // the response is all zero.
    function automatic t_result predict_response(input t_item it);
        t_result     r;
        logic [31:0] elapsed;
        logic [11:0] sample;
        r = '0;
        if (!cfg_en) return r;
        case (it.req_type)
            REQ_READ: begin
                // Twelve bits: the high byte, then the upper nibble of the low byte.
                // Data arriving before any read was ever started is dropped.
                sample = {it.read_byte_high, it.read_byte_low[7:4]};
                if (fill_target == TGT_X) begin
                    raw_x   = sample;
                    rd_seen = 1'b1;
                end else if (fill_target == TGT_Y) begin
                    raw_y   = sample;
                    rd_seen = 1'b1;
                end
            end
            REQ_TX: tx_seen = 1'b1;
            REQ_POLL: begin
                if (mdl_phase == PH_ERR) begin
                    // A refused start is answered by a bus reinit on the next poll,
                    // whatever the pen does.
                    r.action  = ACT_REINIT;
                    mdl_phase = PH_IDLE;
                end else if (mdl_phase == PH_IDLE) begin
                    if (it.pen_down) begin
                        tick_mark = it.now_ticks;
                        mdl_phase = PH_DEBOUNCE;
                    end
                end else if (!it.pen_down) begin
                    mdl_phase = PH_IDLE;
                end else begin
                    case (mdl_phase)
                        PH_DEBOUNCE: begin
                            elapsed = it.now_ticks - tick_mark;
                            if (elapsed > {16'd0, cfg_debounce}) begin
                                tick_mark = it.now_ticks;
                                mdl_phase = PH_SEND_X;
                            end
                        end
                        PH_SEND_X, PH_SEND_Y: begin
                            tx_seen        = 1'b0;
                            r.action       = ACT_SEND;
                            r.command_byte = (mdl_phase == PH_SEND_X) ? CMD_X : CMD_Y;
                            if (!it.start_accepted)
                                mdl_phase = PH_ERR;
                            else
                                mdl_phase = (mdl_phase == PH_SEND_X) ? PH_TX_X : PH_TX_Y;
                        end
                        PH_TX_X, PH_TX_Y: begin
                            if (tx_seen) begin
                                rd_seen     = 1'b0;
                                fill_target = (mdl_phase == PH_TX_X) ? TGT_X : TGT_Y;
                                r.action    = ACT_READ;
                                mdl_phase   = (mdl_phase == PH_TX_X) ? PH_RD_X : PH_RD_Y;
                            end
                        end
                        PH_RD_X: begin
                            if (rd_seen) mdl_phase = PH_SEND_Y;
                        end
                        PH_RD_Y: begin
                            if (rd_seen) begin
                                r.touch_valid = 1'b1;
                                r.pos_x       = raw_x;
                                r.pos_y       = raw_y;
                                mdl_phase     = PH_SEND_X;
                            end
                        end
                        default: mdl_phase = PH_IDLE;
                    endcase
                end
            end
            default: ; // unused request type: no effect at all
        endcase
        return r;
    endfunction

    function automatic t_item make_request(input t_req kind, input logic pen,
                                           input logic [31:0] now, input logic acc,
                                           input logic [7:0] hi, input logic [7:0] lo);
        t_item it;
        it.req_type       = kind;
        it.pen_down       = pen;
        it.now_ticks      = now;
        it.start_accepted = acc;
        it.read_byte_high = hi;
        it.read_byte_low  = lo;
        return it;
    endfunction

    // Picks the next random request with the predicted phase in mind, so most
    // traffic is a well-formed touch session: pen held down, ticks that cross
    // the debounce window, bus events answering the outstanding command or
    // read. A small share is pure noise, and pen-up or refused starts break
    // sessions now and then.
    function automatic t_item pick_request();
        t_item       it;
        logic [31:0] offset;
        it = make_request(REQ_POLL, ($urandom_range(99) < 97), $urandom(),
                          ($urandom_range(99) < 94), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        if ($urandom_range(99) < 8) begin
            it.req_type       = t_req'($urandom_range(3));
            it.pen_down       = 1'($urandom_range(1));
            it.start_accepted = 1'($urandom_range(1));
            return it;
        end
        case (mdl_phase)
            PH_DEBOUNCE: begin
                // Mostly land at or just past the window edge, otherwise at or inside it.
                if ($urandom_range(99) < 60)
                    offset = {16'd0, cfg_debounce} + $urandom_range(2);
                else
                    offset = $urandom_range({16'd0, cfg_debounce});
                it.now_ticks = tick_mark + offset;
            end
            PH_TX_X, PH_TX_Y: begin
                if (!tx_seen && $urandom_range(99) < 70) it.req_type = REQ_TX;
            end
            PH_RD_X, PH_RD_Y: begin
                if (!rd_seen && $urandom_range(99) < 70) it.req_type = REQ_READ;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (response %0d, at %0t)",
                 what, got, want, checked_cnt, $realtime);
    endtask

    // ------------------------------------------------------------------
    // Request side. One request per call; the predictor runs at the edge
    // where the request is taken, so its expectation is queued in order.
    // ------------------------------------------------------------------
    task automatic send_request(input t_item it);
        while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, it.read_byte_low, it.read_byte_high, it.start_accepted,
                       it.now_ticks, it.pen_down};
        i_s_tuser  <= it.req_type;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_responses.push_back(predict_response(it));
        sent_cnt++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_request(pick_request());
    endtask

    // Stops offering requests and waits until every owed response is in and
    // the pipeline has emptied, so the block is idle for a register write.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_ENABLED)
            cfg_en = data[0];
        else if (idx == CFG_DEBOUNCE)
            cfg_debounce = data;
        cfg_cnt++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls, or a long counted hold-off on request
    // from the pressure test while the request side keeps pushing.
    // ------------------------------------------------------------------
    initial begin : response_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && rx_hold_ask) begin
                hold_left   = RX_HOLD_CYCLES;
                rx_hold_ask = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_gaps) begin
                i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Every response taken is compared field by field with the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.command_byte = o_m_tdata[7:0];
            got.pos_x        = o_m_tdata[19:8];
            got.pos_y        = o_m_tdata[31:20];
            got.action       = t_action'(o_m_tuser[1:0]);
            got.touch_valid  = o_m_tuser[2];
            if (pending_responses.size() == 0) begin
                report_mismatch("unexpected response", {o_m_tuser, o_m_tdata[28:0]}, '0);
            end else begin
                want = pending_responses.pop_front();
                if (got.action !== want.action)
                    report_mismatch("action", 32'(got.action), 32'(want.action));
                if (got.command_byte !== want.command_byte)
                    report_mismatch("command_byte", 32'(got.command_byte),
                                    32'(want.command_byte));
                if (got.touch_valid !== want.touch_valid)
                    report_mismatch("touch_valid", 32'(got.touch_valid),
                                    32'(want.touch_valid));
                if (got.pos_x !== want.pos_x)
                    report_mismatch("pos_x", 32'(got.pos_x), 32'(want.pos_x));
                if (got.pos_y !== want.pos_y)
                    report_mismatch("pos_y", 32'(got.pos_y), 32'(want.pos_y));
                if (want.touch_valid) touch_cnt++;
            end
            checked_cnt++;
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the device is marked absent: every request must come back
    // all zero and leave the sequencer where it was.
    task automatic test_disabled_passthrough();
        send_request(make_request(REQ_POLL, 1'b1, 32'hffff_ffff, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_TX, 1'b0, 32'h0, 1'b0, 8'h00, 8'h00));
        send_request(make_request(REQ_READ, 1'b1, 32'h0, 1'b1, 8'hff, 8'hff));
        send_request(make_request(REQ_UNUSED, 1'b1, 32'hffff_ffff, 1'b1, 8'hff, 8'hff));
        wait_drained();
    endtask

    // One full walk through the sequencer: read data before any read, the
    // debounce edge exactly at and one past the window, a refused command
    // start and the reinit that follows with the pen up, a debounce across
    // the tick wrap, a complete X/Y pass with extreme bytes, the unused
    // request type, and pen-up out of a sampling phase.
    task automatic test_directed_touch();
        logic [31:0] t0;
        t0 = 32'h1234_5678;
        write_reg(CFG_ENABLED, 16'd1);
        write_reg(CFG_DEBOUNCE, DEBOUNCE_DEFAULT);
        send_request(make_request(REQ_READ, 1'b0, 32'h0, 1'b0, 8'hff, 8'hff));
        send_request(make_request(REQ_POLL, 1'b1, t0, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, t0 + 32'd10, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, t0 + 32'd11, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, t0, 1'b0, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b0, t0, 1'b0, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, 32'hffff_fff0, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, 32'd5, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, 32'd6, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, 32'd7, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_TX, 1'b0, 32'd0, 1'b0, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, 32'd8, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_READ, 1'b0, 32'd0, 1'b0, 8'hff, 8'hf0));
        send_request(make_request(REQ_POLL, 1'b1, 32'd9, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, 32'd10, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_TX, 1'b1, 32'd0, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_POLL, 1'b1, 32'd11, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_READ, 1'b0, 32'd0, 1'b0, 8'h00, 8'h0f));
        send_request(make_request(REQ_POLL, 1'b1, 32'hffff_ffff, 1'b1, 8'h00, 8'h00));
        send_request(make_request(REQ_UNUSED, 1'b1, 32'hffff_ffff, 1'b1, 8'hff, 8'hff));
        send_request(make_request(REQ_POLL, 1'b0, 32'h0, 1'b1, 8'h00, 8'h00));
        wait_drained();
    endtask

    // The response side stops for a long stretch while requests keep coming
    // at full rate, so both registers fill and the request side must stall.
    task automatic test_output_backpressure();
        write_reg(CFG_DEBOUNCE, 16'd0);
        tx_gaps     = 1'b0;
        rx_hold_ask = 1'b1;
        send_random(30);
        tx_gaps = 1'b1;
        wait_drained();
    endtask

    // Random touch sessions under several debounce lengths, the extremes
    // among them, one stretch with no idling on either side, and a stretch
    // with the device marked absent in the middle of whatever was running.
    task automatic test_random_sweep();
        logic [15:0] window[4];
        int          k;
        window[0] = 16'd0;
        window[1] = 16'hffff;
        window[2] = 16'd1;
        window[3] = 16'($urandom_range(2, 300));
        for (k = 0; k < 4; k++) begin
            write_reg(CFG_DEBOUNCE, window[k]);
            if (k == 2) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            send_random(85);
            tx_gaps = 1'b1;
            rx_gaps = 1'b1;
            wait_drained();
            if (k == 1) begin
                write_reg(CFG_ENABLED, 16'd0);
                send_random(15);
                wait_drained();
                write_reg(CFG_ENABLED, 16'd1);
            end
        end
    endtask

    initial begin : main
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_passthrough();
        test_directed_touch();
        test_output_backpressure();
        test_random_sweep();
        wait_drained();
        if (pending_responses.size() != 0)
            report_mismatch("responses never delivered", pending_responses.size(), '0);
        $display("Sent %0d requests, checked %0d responses (%0d touch pairs), %0d writes.",
                 sent_cnt, checked_cnt, touch_cnt, cfg_cnt);
        $display("%s %s", "Debounce windows 0, 1, 65535 and one random;",
                 "device absent and present; long output hold-off.");
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
